FILE: sv/ccsn_pkg.sv
package ccsn_pkg;

  // Most tokens that one input byte can release from the comment/substitution front
  localparam int NTOK = 6;
  localparam int NW   = $clog2(NTOK + 1);

  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_E3     = 8'hE3;
  localparam logic [7:0] CH_80     = 8'h80;

  // One queue entry: the tokens released by one input byte
  typedef struct packed {
    logic                     last;
    logic [NW-1:0]            n;
    logic [NTOK-1:0][7:0]     tok;
  } bundle_t;

  function automatic logic is_pad(logic [7:0] c);
    return (c == CH_SEMI) || (c == CH_LPAREN) || (c == CH_RPAREN) ||
           (c == CH_LBRACE) || (c == CH_RBRACE) || (c == CH_COMMA) ||
           (c == CH_BSLASH);
  endfunction

  function automatic logic wants_newline(logic [7:0] c);
    return (c == CH_SEMI) || (c == CH_BSLASH) || (c == CH_LBRACE) ||
           (c == CH_RBRACE);
  endfunction

endpackage

FILE: sv/ccsn_front.sv
module ccsn_front import ccsn_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  text_byte,
  input  logic        end_of_text,
  input  logic        q_full,
  output logic        q_push,
  output bundle_t     q_data
);

  localparam logic [1:0] MODE_CODE  = 2'd0;
  localparam logic [1:0] MODE_LINE  = 2'd1;
  localparam logic [1:0] MODE_BLOCK = 2'd2;

  typedef struct packed {
    logic [1:0]           cnt;
    logic [7:0]           la;
    logic [NW-1:0]        n;
    logic [NTOK-1:0][7:0] tok;
  } sub_t;

  logic [1:0] mode;
  logic       held;
  logic [7:0] la_byte;
  logic [1:0] la_count;

  logic [1:0] mode_next;
  logic       held_next;
  sub_t       acc;
  logic       accept;

  function automatic sub_t push_tok(sub_t a, logic [7:0] x);
    sub_t r;
    r = a;
    if (r.n < NW'(NTOK)) begin
      r.tok[r.n] = x;
      r.n = r.n + NW'(1);
    end
    return r;
  endfunction

  function automatic sub_t subst_feed(sub_t a, logic [7:0] b);
    sub_t r;
    logic done;
    r = a;
    done = 1'b0;
    if (r.cnt == 2'd1 && r.la != CH_E3) begin
      r = push_tok(r, r.la);
      if (b != CH_NL) r = push_tok(r, CH_NL);
      r.cnt = 2'd0;
    end else if (r.cnt == 2'd1) begin
      if (b == CH_80) begin
        r.cnt = 2'd2;
        done = 1'b1;
      end else begin
        r = push_tok(r, CH_E3);
        r.cnt = 2'd0;
      end
    end else if (r.cnt == 2'd2) begin
      r.cnt = 2'd0;
      if (b == CH_80) begin
        r = push_tok(r, CH_SP);
        done = 1'b1;
      end else begin
        r = push_tok(r, CH_E3);
        r = push_tok(r, CH_80);
      end
    end
    if (!done) begin
      r.cnt = 2'd0;
      if (b == CH_TAB) begin
        r = push_tok(r, CH_SP);
      end else if (b == CH_E3 || wants_newline(b)) begin
        r.la = b;
        r.cnt = 2'd1;
      end else begin
        r = push_tok(r, b);
      end
    end
    return r;
  endfunction

  function automatic sub_t subst_flush(sub_t a);
    sub_t r;
    r = a;
    if (r.cnt == 2'd1 && r.la != CH_E3) begin
      r = push_tok(r, r.la);
      r = push_tok(r, CH_NL);
    end else if (r.cnt == 2'd1) begin
      r = push_tok(r, CH_E3);
    end else if (r.cnt == 2'd2) begin
      r = push_tok(r, CH_E3);
      r = push_tok(r, CH_80);
    end
    r.cnt = 2'd0;
    return r;
  endfunction

  // Strip comments, then substitute; all tokens of one byte are computed combinationally
  always_comb begin
    logic gone;
    acc       = '{cnt: la_count, la: la_byte, n: '0, tok: '0};
    mode_next = mode;
    held_next = held;
    gone      = 1'b0;
    case (mode)
      MODE_LINE: begin
        if (text_byte == CH_NL) begin
          mode_next = MODE_CODE;
          acc = subst_feed(acc, text_byte);
        end
      end
      MODE_BLOCK: begin
        if (held) begin
          held_next = 1'b0;
          if (text_byte == CH_SLASH) begin
            mode_next = MODE_CODE;
            gone = 1'b1;
          end
        end
        if (!gone && text_byte == CH_STAR) held_next = 1'b1;
      end
      default: begin
        if (held) begin
          held_next = 1'b0;
          if (text_byte == CH_STAR) begin
            mode_next = MODE_BLOCK;
            gone = 1'b1;
          end else if (text_byte == CH_SLASH) begin
            mode_next = MODE_LINE;
            gone = 1'b1;
          end else begin
            acc = subst_feed(acc, CH_SLASH);
          end
        end
        if (!gone) begin
          if (text_byte == CH_SLASH) held_next = 1'b1;
          else acc = subst_feed(acc, text_byte);
        end
      end
    endcase
    if (end_of_text) begin
      if (mode_next == MODE_CODE && held_next) acc = subst_feed(acc, CH_SLASH);
      held_next = 1'b0;
      acc = subst_flush(acc);
    end
  end

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept && (acc.n != '0 || end_of_text);
  assign q_data   = '{last: end_of_text, n: acc.n, tok: acc.tok};

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_CODE;
      held     <= 1'b0;
      la_count <= 2'd0;
    end else if (accept) begin
      if (end_of_text) begin
        mode     <= MODE_CODE;
        held     <= 1'b0;
        la_count <= 2'd0;
      end else begin
        mode     <= mode_next;
        held     <= held_next;
        la_count <= acc.cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) la_byte <= acc.la;
  end

endmodule

FILE: sv/ccsn_fifo.sv
module ccsn_fifo import ccsn_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  bundle_t wdata,
  output logic    full,
  output logic    valid,
  input  logic    pop,
  output bundle_t rdata
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  bundle_t         mem [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full  = (count == CW'(DEPTH));
  assign valid = (count != '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      if (pop)  rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      if (push && !pop)      count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wdata;
  end

endmodule

FILE: sv/ccsn_back.sv
module ccsn_back import ccsn_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  bundle_t    q_data,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       end_of_output
);

  logic [NW-1:0] ti;
  logic [1:0]    ph;
  logic          pws;
  logic          emitted_any;

  logic       step;
  logic [7:0] t;
  logic       pad;
  logic [7:0] cand;
  logic       tok_end;
  logic       empty;
  logic       bundle_end;
  logic       later_sp;
  logic       drop;
  logic       last_emit;
  logic       emit;

  assign step  = q_valid && (!out_valid || out_ready);
  assign t     = q_data.tok[ti];
  assign pad   = is_pad(t);
  // Padded punctuation walks three phases: space, the byte, space
  assign cand  = (pad && ph != 2'd1) ? CH_SP : t;
  assign tok_end    = !pad || ph == 2'd2;
  assign empty      = (q_data.n == '0);
  assign bundle_end = empty || (tok_end && ti == q_data.n - NW'(1));
  assign drop       = !empty && cand == CH_SP && pws;

  always_comb begin
    later_sp = 1'b1;
    for (int j = 0; j < NTOK; j++) begin
      if (NW'(j) > ti && NW'(j) < q_data.n && q_data.tok[j] != CH_SP) later_sp = 1'b0;
    end
  end

  // A space is the final byte when everything after it will collapse away
  assign last_emit = bundle_end || (cand == CH_SP && tok_end && later_sp);
  assign emit      = empty ? q_data.last
                           : (!drop || (q_data.last && bundle_end && !emitted_any));
  assign q_pop     = step && bundle_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      ti          <= '0;
      ph          <= 2'd0;
      pws         <= 1'b0;
      emitted_any <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (step) begin
        if (bundle_end) begin
          ti          <= '0;
          ph          <= 2'd0;
          emitted_any <= 1'b0;
          if (q_data.last) pws <= 1'b0;
          else pws <= (cand == CH_SP);
        end else begin
          pws         <= (cand == CH_SP);
          emitted_any <= emitted_any || !drop;
          if (tok_end) begin
            ti <= ti + NW'(1);
            ph <= 2'd0;
          end else begin
            ph <= ph + 2'd1;
          end
        end
      end
      if (step && emit)   out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      if (empty || drop) begin
        out_byte      <= 8'h00;
        byte_valid    <= 1'b0;
        end_of_output <= 1'b1;
      end else begin
        out_byte      <= cand;
        byte_valid    <= 1'b1;
        end_of_output <= q_data.last && last_emit;
      end
    end
  end

endmodule

FILE: sv/c_comment_strip_normalizer_core.sv
// Flow: the first result of a byte passes the queue write, then the output
// register; held bytes leave later. Input: one byte per cycle while the queue
// is not full. The output walker steps one candidate byte per cycle while
// out_ready allows; a padded punctuation byte walks space, byte, space, and
// the walker sets the sustained rate.
// Reset (rst, synchronous): clears comment state, lookahead, queue and output.
module c_comment_strip_normalizer_core import ccsn_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] text_byte,
  input  logic       end_of_text,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       end_of_output
);

  // Front: strip comments and substitute, one transaction per cycle while the
  // queue is not full, and push the resulting token group into the queue.
  logic    q_push;
  logic    q_full;
  logic    q_valid;
  logic    q_pop;
  bundle_t q_wdata;
  bundle_t q_rdata;

  ccsn_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .text_byte   (text_byte),
    .end_of_text (end_of_text),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_wdata)
  );

  // Queue: hold token groups so the front keeps accepting while the back
  // expands padding or waits on out_ready.
  ccsn_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .valid (q_valid),
    .pop   (q_pop),
    .rdata (q_rdata)
  );

  // Back: pad, collapse spaces and drive the registered output transaction.
  ccsn_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_data        (q_rdata),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .byte_valid    (byte_valid),
    .end_of_output (end_of_output)
  );

endmodule

FILE: sv/ccsn_checker.sv
module ccsn_checker import ccsn_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       byte_valid,
  input logic       end_of_output
);

  logic prev_sp;

  // Track whether the last delivered byte of the current file was a space
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_sp <= 1'b0;
    end else if (out_valid && out_ready) begin
      prev_sp <= end_of_output ? 1'b0 : (byte_valid && out_byte == CH_SP);
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(end_of_output))
    else $error("output transaction changed while stalled");

  a_empty_is_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> end_of_output && out_byte == 8'h00)
    else $error("empty result without end mark");

  a_no_double_space: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_valid && out_byte == CH_SP |-> !prev_sp)
    else $error("two spaces in a row");

  a_no_tab: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_valid |-> out_byte != CH_TAB)
    else $error("tab leaked to output");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind c_comment_strip_normalizer_core ccsn_checker u_ccsn_checker (.*);
